// ===== rtl/core/index_scatter_accumulate_macros.svh =====
// Assertion helpers for the scatter-accumulate block
`ifndef INDEX_SCATTER_ACCUMULATE_MACROS_SVH
`define INDEX_SCATTER_ACCUMULATE_MACROS_SVH

// same-cycle implication, held off during reset
`define ISA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define ISA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/isa_pkg.sv =====
package isa_pkg;

	localparam int DEF_STORE_DEPTH = 4096;
	localparam int DEF_DATA_WIDTH  = 32;

	localparam int IDX_W   = 12;  // index and direct address fields
	localparam int REG_W   = 13;  // geometry registers
	localparam int SLOT_W  = 26;  // row*cols+col
	localparam int FLAT_W  = 40;  // slot*slice+offset
	localparam int OUT_W   = 32;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ACC  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BOUNDS = 2'd1;
	localparam logic [1:0] ST_PAST   = 2'd2;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_ROWS  = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;
	localparam logic [1:0] REG_SLICE = 2'd3;

	localparam logic [REG_W-1:0] RST_ROWS  = 13'd4096;
	localparam logic [REG_W-1:0] RST_COLS  = 13'd1;
	localparam logic [REG_W-1:0] RST_SLICE = 13'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOT,
		S_ADDR,
		S_ACCESS,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

endpackage

// ===== rtl/core/index_scatter_accumulate.sv =====
// Scatter-accumulate engine: load, read and indexed wrapping add over one store.
// done pulses once an accepted command has passed SLOT, ADDR, ACCESS and FINISH; busy is
// high in those states, so a new command waits out the two chained address multiplies
// and the registered read of the store ahead of its write-back.
// Reset clears control, result strobe and registers; store contents stay undefined
// until written, with no clearing pass. Results are never stalled by the receiver.
`include "index_scatter_accumulate_macros.svh"

module index_scatter_accumulate #(
	parameter int STORE_DEPTH = isa_pkg::DEF_STORE_DEPTH,
	parameter int DATA_WIDTH  = isa_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command channel
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic [isa_pkg::IDX_W-1:0]    row_index,
	input  logic [isa_pkg::IDX_W-1:0]    col_index,
	input  logic [isa_pkg::IDX_W-1:0]    slice_offset,
	input  logic [isa_pkg::IDX_W-1:0]    direct_address,
	input  logic signed [31:0]           operand_value,
	// result channel
	output logic                         done,
	output logic signed [isa_pkg::OUT_W-1:0] read_data,
	output logic [1:0]                   status,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [isa_pkg::PADDR_W-1:0]  paddr,
	input  logic [isa_pkg::PDATA_W-1:0]  pwdata,
	output logic [isa_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	import isa_pkg::*;

	localparam int ADDR_W = $clog2(STORE_DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers. Writes must land only while idle; the
	// block does not enforce it. The datapath reads them directly without a shadow copy.
	// ------------------------------------------------------------------
	logic             index_mode_q;
	logic [REG_W-1:0] row_count_q;
	logic [REG_W-1:0] column_count_q;
	logic [REG_W-1:0] slice_length_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_mode_q   <= 1'b0;
			row_count_q    <= RST_ROWS;
			column_count_q <= RST_COLS;
			slice_length_q <= RST_SLICE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODE:  index_mode_q   <= pwdata[0];
				REG_ROWS:  row_count_q    <= pwdata[REG_W-1:0];
				REG_COLS:  column_count_q <= pwdata[REG_W-1:0];
				REG_SLICE: slice_length_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:  prdata = PDATA_W'(index_mode_q);
			REG_ROWS:  prdata = PDATA_W'(row_count_q);
			REG_COLS:  prdata = PDATA_W'(column_count_q);
			REG_SLICE: prdata = PDATA_W'(slice_length_q);
			default:   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: SLOT (first multiply, bounds) -> ADDR (second multiply)
	// -> ACCESS (range check, store read) -> FINISH (add, write-back)
	// ------------------------------------------------------------------
	state_t state_q, state_d;
	logic   accept;

	store_ctl_t            ctl;
	logic [ADDR_W-1:0]     rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [DATA_WIDTH-1:0] wr_data;

	logic [1:0]            cmd_q;
	logic [IDX_W-1:0]      row_q;
	logic [IDX_W-1:0]      col_q;
	logic [IDX_W-1:0]      off_q;
	logic [IDX_W-1:0]      daddr_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  bad_q;
	logic [FLAT_W-1:0]     flat_q;
	logic [ADDR_W-1:0]     mem_addr_q;
	logic                  ok_q;
	logic [1:0]            stat_q;

	logic [FLAT_W-1:0]     eff_addr;
	logic                  past;
	logic [1:0]            stat_d;

	logic                  done_q;
	logic [OUT_W-1:0]      read_data_q;
	logic [1:0]            status_q;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		ctl.rd_en = 1'b0;
		ctl.wr_en = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = S_SLOT;
				end
			end
			S_SLOT:   state_d = S_ADDR;
			S_ADDR:   state_d = S_ACCESS;
			S_ACCESS: begin
				ctl.rd_en = (stat_d == ST_OK) && (cmd_q == CMD_ACC || cmd_q == CMD_READ);
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				ctl.wr_en = ok_q && (cmd_q == CMD_LOAD || cmd_q == CMD_ACC);
				state_d   = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// effective address and status, resolved in ACCESS
	always_comb begin
		eff_addr = (cmd_q == CMD_ACC) ? flat_q : FLAT_W'(daddr_q);
		past     = eff_addr >= FLAT_W'(STORE_DEPTH);
		case (cmd_q)
			CMD_ACC:            stat_d = bad_q ? ST_BOUNDS : (past ? ST_PAST : ST_OK);
			CMD_LOAD, CMD_READ: stat_d = past ? ST_PAST : ST_OK;
			default:            stat_d = ST_OK;
		endcase
	end

	assign rd_addr = eff_addr[ADDR_W-1:0];
	// wrapping add at store width
	assign wr_data = (cmd_q == CMD_LOAD) ? val_q : rd_data + val_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			row_q   <= row_index;
			col_q   <= col_index;
			off_q   <= slice_offset;
			daddr_q <= direct_address;
			val_q   <= DATA_WIDTH'(operand_value);  // sign-extends or truncates
		end
		if (state_q == S_SLOT) begin
			slot_q <= index_mode_q
				? SLOT_W'(row_q) * SLOT_W'(column_count_q) + SLOT_W'(col_q)
				: SLOT_W'(row_q);
			bad_q  <= ({1'b0, row_q} >= row_count_q)
				|| ({1'b0, off_q} >= slice_length_q)
				|| (index_mode_q && ({1'b0, col_q} >= column_count_q));
		end
		if (state_q == S_ADDR) begin
			flat_q <= FLAT_W'(slot_q) * FLAT_W'(slice_length_q) + FLAT_W'(off_q);
		end
		if (state_q == S_ACCESS) begin
			mem_addr_q <= rd_addr;
			ok_q       <= stat_d == ST_OK;
			stat_q     <= stat_d;
		end
	end

	// result register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			read_data_q <= '0;
			status_q    <= ST_OK;
		end else begin
			done_q <= state_q == S_FINISH;
			if (state_q == S_FINISH) begin
				read_data_q <= (ok_q && cmd_q == CMD_READ) ? OUT_W'(rd_data) : '0;
				status_q    <= stat_q;
			end
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	isa_store #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_addr (mem_addr_q),
		.wr_data (wr_data)
	);

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`ISA_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == S_SLOT,
		"accepted command did not enter the sequencer")
	`ISA_ASSERT_NOW(a_done_after_finish, clk, arst_n, done, $past(state_q) == S_FINISH,
		"result strobe without a finished command")
	`ISA_ASSERT_NOW(a_write_in_range, clk, arst_n, ctl.wr_en,
		FLAT_W'(mem_addr_q) < FLAT_W'(STORE_DEPTH), "store write past the end")
	`ISA_ASSERT_NOW(a_error_no_data, clk, arst_n, done && status != ST_OK, read_data == '0,
		"error result carries data")

endmodule

// ===== rtl/core/isa_store.sv =====
module isa_store #(
	parameter int DEPTH = isa_pkg::DEF_STORE_DEPTH,
	parameter int WIDTH = isa_pkg::DEF_DATA_WIDTH
) (
	input  logic                     clk,
	input  isa_pkg::store_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== test/index_scatter_accumulate_tb.sv =====
`timescale 1ns / 1ps

module index_scatter_accumulate_tb;
	import isa_pkg::*;

	// cmd 3 has no name in the package: it is the do-nothing command
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int DEPTH = DEF_STORE_DEPTH;

	// one command transfer as the driver sees it
	typedef struct {
		logic [1:0]        op;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  off;
		logic [IDX_W-1:0]  addr;
		logic [31:0]       val;
		int                gap;    // idle cycles ahead of this transfer
		bit                drain;  // marker: hold off until every result is back
	} cmd_item_t;

	// one result transfer
	typedef struct {
		logic [OUT_W-1:0] data;
		logic [1:0]       st;
	} acc_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         cmd = CMD_LOAD;
	logic [IDX_W-1:0]   row_index = '0;
	logic [IDX_W-1:0]   col_index = '0;
	logic [IDX_W-1:0]   slice_offset = '0;
	logic [IDX_W-1:0]   direct_address = '0;
	logic signed [31:0] operand_value = '0;
	logic               done;
	logic signed [OUT_W-1:0] read_data;
	logic [1:0]         status;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	index_scatter_accumulate uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.row_index      (row_index),
		.col_index      (col_index),
		.slice_offset   (slice_offset),
		.direct_address (direct_address),
		.operand_value  (operand_value),
		.done           (done),
		.read_data      (read_data),
		.status         (status),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// geometry as last written over the register port; shared by the
	// generator and the predictor, safe since writes only happen when idle
	logic             geo_mode  = 1'b0;
	logic [REG_W-1:0] geo_rows  = RST_ROWS;
	logic [REG_W-1:0] geo_cols  = RST_COLS;
	logic [REG_W-1:0] geo_slice = RST_SLICE;

	// predicted store contents, and which entries the stimulus has loaded
	logic [31:0] acc_mem [DEPTH];
	bit          loaded  [DEPTH];

	cmd_item_t        pending [$];   // commands not yet handed to the driver
	acc_result_t      want_q  [$];   // predicted results, oldest first
	logic [IDX_W-1:0] hot_q   [$];   // recently touched addresses, for re-hits

	cmd_item_t cur;
	bit        have_item = 1'b0;
	bit        driving   = 1'b0;
	int        gap_left  = 0;
	bit        xfer_taken = 1'b0;
	bit        quiet_run = 1'b0;
	int        errors = 0;

	// Element address of an accumulate under the current geometry, with
	// the status it earns: out of bounds before the multiply, past the store after.
	function automatic longint unsigned elem_addr(cmd_item_t it, output logic [1:0] st);
		longint unsigned slot;
		longint unsigned flat;
		st = ST_OK;
		flat = 0;
		if (it.row >= geo_rows || it.off >= geo_slice || (geo_mode && it.col >= geo_cols)) begin
			st = ST_BOUNDS;
		end else begin
			slot = geo_mode ? 64'(it.row) * 64'(geo_cols) + 64'(it.col) : 64'(it.row);
			flat = slot * 64'(geo_slice) + 64'(it.off);
			if (flat >= DEPTH)
				st = ST_PAST;
		end
		return flat;
	endfunction

	// Expected result of one accepted command; updates the predicted store.
	function automatic acc_result_t scatter_predict(cmd_item_t it);
		acc_result_t     r;
		longint unsigned a;
		logic [1:0]      st;
		r.data = '0;
		r.st = ST_OK;
		case (it.op)
			CMD_LOAD: acc_mem[it.addr] = it.val;
			CMD_READ: r.data = acc_mem[it.addr];
			CMD_ACC: begin
				a = elem_addr(it, st);
				r.st = st;
				if (st == ST_OK)
					acc_mem[a[IDX_W-1:0]] = acc_mem[a[IDX_W-1:0]] + it.val;  // wraps at 32 bits
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_item_t mk(logic [1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
			logic [IDX_W-1:0] off, logic [IDX_W-1:0] addr, logic [31:0] val);
		cmd_item_t it;
		it.op = op;
		it.row = row;
		it.col = col;
		it.off = off;
		it.addr = addr;
		it.val = val;
		it.gap = 0;
		it.drain = 1'b0;
		return it;
	endfunction

	// sender gap; runs of back-to-back transfers come and go
	function automatic int draw_gap();
		if ($urandom_range(0, 39) == 0)
			quiet_run = !quiet_run;
		return quiet_run ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic void note_hot(logic [IDX_W-1:0] a);
		hot_q.push_back(a);
		if (hot_q.size() > 16)
			hot_q.delete(0);
	endfunction

	// Queue a command. Any read or accumulate that would touch an entry never
	// loaded gets a load of that entry placed ahead of it.
	task automatic queue_item(cmd_item_t it);
		cmd_item_t       ld;
		logic [1:0]      st;
		longint unsigned a;
		bit              need;
		bit              touches;
		logic [IDX_W-1:0] na;
		need = 1'b0;
		touches = 1'b0;
		na = it.addr;
		if (it.op == CMD_READ || it.op == CMD_LOAD) begin
			touches = 1'b1;
			need = (it.op == CMD_READ) && !loaded[na];
		end else if (it.op == CMD_ACC) begin
			a = elem_addr(it, st);
			if (st == ST_OK) begin
				na = a[IDX_W-1:0];
				touches = 1'b1;
				need = !loaded[na];
			end
		end
		if (need) begin
			ld = mk(CMD_LOAD, IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)),
				IDX_W'($urandom_range(0, 4095)), na, $urandom);
			ld.gap = draw_gap();
			pending.push_back(ld);
		end
		if (touches) begin
			loaded[na] = 1'b1;
			note_hot(na);
		end
		it.gap = draw_gap();
		it.drain = 1'b0;
		pending.push_back(it);
	endtask

	function automatic logic [IDX_W-1:0] pick_below(logic [REG_W-1:0] n);
		int lim;
		if (n == 0)
			return IDX_W'($urandom_range(0, 4095));
		// half the time stay in a tiny window so entries get hit again
		lim = $urandom_range(0, 1) ? int'(n) : (n < 4 ? int'(n) : 4);
		return IDX_W'($urandom_range(0, lim - 1));
	endfunction

	task automatic queue_random();
		cmd_item_t it;
		int        sel;
		it = mk(CMD_NONE, IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)),
			IDX_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 4095)), $urandom);
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			it.op = CMD_ACC;
			if ($urandom_range(0, 3) != 0) begin
				it.row = pick_below(geo_rows);
				it.col = pick_below(geo_cols);
				it.off = pick_below(geo_slice);
			end
		end else if (sel < 65) begin
			it.op = CMD_LOAD;
			if (hot_q.size() != 0 && $urandom_range(0, 1))
				it.addr = hot_q[$urandom_range(0, hot_q.size() - 1)];
		end else if (sel < 90) begin
			it.op = CMD_READ;
			if (hot_q.size() != 0 && $urandom_range(0, 3) != 0)
				it.addr = hot_q[$urandom_range(0, hot_q.size() - 1)];
		end else if (sel >= 95) begin
			it.op = 2'($urandom_range(0, 3));
		end
		queue_item(it);
	endtask

	// hold the sender until every predicted result is back
	task automatic queue_drain();
		cmd_item_t d;
		d = mk(CMD_NONE, '0, '0, '0, '0, '0);
		d.drain = 1'b1;
		pending.push_back(d);
	endtask

	task automatic reg_read(logic [1:0] idx, logic [PDATA_W-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d readback, expected %h got %h", $time, idx, want, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [REG_W-1:0] v);
		logic [PDATA_W-1:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE:  geo_mode = v[0];
			REG_ROWS:  geo_rows = v;
			REG_COLS:  geo_cols = v;
			REG_SLICE: geo_slice = v;
			default: ;
		endcase
		want = (idx == REG_MODE) ? PDATA_W'(v[0]) : PDATA_W'(v);
		reg_read(idx, want);
	endtask

	task automatic set_geometry(logic m, logic [REG_W-1:0] r, logic [REG_W-1:0] c,
			logic [REG_W-1:0] s);
		reg_write(REG_MODE, REG_W'(m));
		reg_write(REG_ROWS, r);
		reg_write(REG_COLS, c);
		reg_write(REG_SLICE, s);
	endtask

	function automatic logic [REG_W-1:0] pick_dim();
		case ($urandom_range(0, 3))
			0: return REG_W'(1);
			1: return REG_W'(4096);
			2: return REG_W'($urandom_range(1, 16));
			default: return REG_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// Wait for the queue to empty and every result to come back, reporting any
	// that never arrive, then wait on so the block is idle before any register write.
	task automatic settle();
		int waited;
		while (pending.size() != 0 || have_item)
			@(posedge clk);
		waited = 0;
		while (want_q.size() != 0 && waited < 50) begin
			@(posedge clk);
			waited++;
		end
		if (want_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, want_q.size());
			errors++;
			want_q.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	// Driver: changes inputs at the falling edge. A transfer that went in at
	// the last rising edge frees the slot; the next command waits out its gap.
	always @(negedge clk) begin : cmd_driver
		cmd_item_t nx;
		if (arst_n) begin
			if (start && xfer_taken) begin
				have_item = 1'b0;
				driving = 1'b0;
			end
			if (!have_item && pending.size() != 0) begin
				if (pending[0].drain) begin
					if (want_q.size() == 0)
						pending.delete(0);
				end else begin
					nx = pending.pop_front();
					cur = nx;
					gap_left = nx.gap;
					have_item = 1'b1;
				end
			end
			if (have_item && !driving) begin
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					driving = 1'b1;
					cmd <= cur.op;
					row_index <= cur.row;
					col_index <= cur.col;
					slice_offset <= cur.off;
					direct_address <= cur.addr;
					operand_value <= cur.val;
				end
			end
			// one assignment per step, so back-to-back commands keep start high
			start <= driving;
		end
	end

	// Monitor: checks a result strobe against the oldest prediction, then
	// predicts the command accepted at this edge.
	always @(posedge clk) begin : result_check
		acc_result_t exp_r;
		cmd_item_t   seen;
		if (arst_n) begin
			if (done) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected result, expected none got data %h status %0d",
						$time, read_data, status);
					errors++;
				end else begin
					exp_r = want_q.pop_front();
					if (read_data !== exp_r.data) begin
						$display("%0t: read_data mismatch, expected %h got %h",
							$time, exp_r.data, read_data);
						errors++;
					end
					if (status !== exp_r.st) begin
						$display("%0t: status mismatch, expected %0d got %0d",
							$time, exp_r.st, status);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				seen = mk(cmd, row_index, col_index, slice_offset, direct_address, operand_value);
				want_q.push_back(scatter_predict(seen));
			end
			xfer_taken <= start && !busy;
		end else begin
			xfer_taken <= 1'b0;
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		logic [31:0] ones;
		ones = '1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers come up at their reset values
		reg_read(REG_MODE, '0);
		reg_read(REG_ROWS, PDATA_W'(RST_ROWS));
		reg_read(REG_COLS, PDATA_W'(RST_COLS));
		reg_read(REG_SLICE, PDATA_W'(RST_SLICE));

		// reset geometry: 1-D, slice of one, so the element address is the row
		queue_item(mk(CMD_LOAD, '1, '1, '1, 12'd0, 32'h7fff_ffff));
		queue_item(mk(CMD_LOAD, '0, '0, '0, 12'd4095, 32'h8000_0000));
		queue_item(mk(CMD_LOAD, '0, '0, '0, 12'd1, ones));
		queue_item(mk(CMD_ACC, 12'd0, '0, 12'd0, '1, 32'd1));            // wraps to min
		queue_item(mk(CMD_ACC, 12'd4095, '0, 12'd0, '0, 32'h8000_0000)); // wraps to zero
		queue_item(mk(CMD_ACC, 12'd1, 12'd4095, 12'd0, '1, 32'h7fff_ffff)); // column ignored in 1-D
		queue_item(mk(CMD_READ, '1, '1, '1, 12'd0, ones));
		queue_item(mk(CMD_READ, '0, '0, '0, 12'd4095, '0));
		queue_item(mk(CMD_READ, '0, '0, '0, 12'd1, '0));
		queue_item(mk(CMD_ACC, 12'd0, '0, 12'd1, '0, 32'd7));            // offset out of bounds
		queue_item(mk(CMD_ACC, 12'd4095, '1, 12'd4095, '1, ones));       // offset out of bounds
		queue_item(mk(CMD_NONE, '1, '1, '1, '1, ones));
		queue_item(mk(CMD_NONE, '0, '0, '0, '0, '0));
		queue_item(mk(CMD_LOAD, '1, '1, '1, 12'd2, '0));
		queue_item(mk(CMD_READ, '1, '1, '1, 12'd2, ones));
		settle();

		// largest geometry: most in-bound addresses land past the store
		set_geometry(1'b1, 13'd4096, 13'd4096, 13'd4096);
		queue_item(mk(CMD_ACC, 12'd0, 12'd0, 12'd0, '0, 32'hffff_fffb));
		queue_item(mk(CMD_ACC, 12'd0, 12'd0, 12'd4095, '0, 32'd3));
		queue_item(mk(CMD_ACC, 12'd0, 12'd1, 12'd0, '0, 32'd3));        // first address past store
		queue_item(mk(CMD_ACC, 12'd4095, 12'd4095, 12'd4095, '0, ones));
		queue_item(mk(CMD_READ, '0, '0, '0, 12'd0, '0));
		settle();

		// 2-D with a single column: column index becomes a bound
		set_geometry(1'b1, 13'd4096, 13'd1, 13'd1);
		queue_item(mk(CMD_ACC, 12'd0, 12'd1, 12'd0, '0, 32'd9));
		queue_item(mk(CMD_ACC, 12'd5, 12'd0, 12'd0, '0, 32'd9));
		settle();

		// zero row bound rejects every accumulate
		set_geometry(1'b0, 13'd0, 13'd1, 13'd1);
		queue_item(mk(CMD_ACC, 12'd0, 12'd0, 12'd0, '0, 32'd1));
		settle();

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_geometry(1'b0, RST_ROWS, RST_COLS, RST_SLICE);
				1: set_geometry(1'b1, 13'd64, 13'd64, 13'd1);
				2: set_geometry(1'b0, 13'd16, 13'd1, 13'd256);
				3: set_geometry(1'b1, 13'd1, 13'd1, 13'd1);
				4: set_geometry(1'b1, 13'd4096, 13'd4096, 13'd4096);
				5: set_geometry(1'b1, 13'd8, 13'd8, 13'd64);
				default: set_geometry(1'($urandom_range(0, 1)), pick_dim(), pick_dim(),
					pick_dim());
			endcase
			for (n = 0; n < 180; n++) begin
				if (n == 90)
					queue_drain();
				queue_random();
			end
			settle();
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/isa_pkg.sv
rtl/core/isa_store.sv
rtl/core/index_scatter_accumulate.sv
test/index_scatter_accumulate_tb.sv
